// ----- rtl/cpu16_pkg.sv -----
// Package for the 65816-style execute unit: operation codes, flag positions,
// reset values and the result struct. No dependencies.
package cpu16_pkg;
   typedef enum logic [5:0] {
      OP_NOP = 6'd0, OP_ADC = 6'd1, OP_SBC = 6'd2, OP_AND = 6'd3, OP_ORA = 6'd4,
      OP_EOR = 6'd5, OP_CMP = 6'd6, OP_CPX = 6'd7, OP_CPY = 6'd8, OP_BIT = 6'd9,
      OP_LDA = 6'd10, OP_LDX = 6'd11, OP_LDY = 6'd12, OP_STA = 6'd13, OP_STZ = 6'd14,
      OP_INC = 6'd15, OP_DEC = 6'd16, OP_ASL = 6'd17, OP_LSR = 6'd18, OP_INA = 6'd19,
      OP_DEA = 6'd20, OP_DEX = 6'd21, OP_TAX = 6'd22, OP_TAY = 6'd23, OP_TXA = 6'd24,
      OP_TYA = 6'd25, OP_TSX = 6'd26, OP_TXS = 6'd27, OP_TCS = 6'd28, OP_TCD = 6'd29,
      OP_XBA = 6'd30, OP_REP = 6'd31, OP_SEP = 6'd32, OP_CLC = 6'd33, OP_SEI = 6'd34,
      OP_PLP = 6'd35, OP_XCE = 6'd36, OP_BRA = 6'd37, OP_BEQ = 6'd38, OP_BNE = 6'd39,
      OP_BCC = 6'd40, OP_BCS = 6'd41, OP_BPL = 6'd42, OP_BMI = 6'd43, OP_BVC = 6'd44,
      OP_BVS = 6'd45
   } op_type;

   localparam int FL_C = 0;
   localparam int FL_Z = 1;
   localparam int FL_I = 2;
   localparam int FL_X = 4;
   localparam int FL_M = 5;
   localparam int FL_V = 6;
   localparam int FL_N = 7;

   localparam logic [7:0]  STATUS_RESET = 8'h34;
   localparam logic [15:0] SP_RESET     = 16'h01FF;
   localparam logic [7:0]  STACK_PAGE   = 8'h01;

   typedef struct packed {
      logic [7:0]  status;
      logic [15:0] acc;
      logic        wr_valid;
      logic [15:0] wr_data;
      logic        wr_wide;
      logic        branch;
   } result_type;
endpackage

// ----- rtl/cpu16_core.sv -----
// Register file and single-pass execute logic of the 65816-style unit.
// Depends on cpu16_pkg.
module cpu16_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [5:0]            kind,
   input  logic [15:0]           operand,
   output cpu16_pkg::result_type result
);
   logic [15:0] acc_ff, acc_in, x_ff, x_in, y_ff, y_in, sp_ff, sp_in, d_ff, d_in;
   logic [7:0]  p_ff, p_in;
   logic        e_ff, e_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0; x_ff <= '0; y_ff <= '0; sp_ff <= cpu16_pkg::SP_RESET;
         d_ff <= '0; p_ff <= cpu16_pkg::STATUS_RESET; e_ff <= 1'b1;
      end else if (step) begin
         acc_ff <= acc_in; x_ff <= x_in; y_ff <= y_in; sp_ff <= sp_in;
         d_ff <= d_in; p_ff <= p_in; e_ff <= e_in;
      end
   end

   logic        mw, xw;
   logic [15:0] am, xm, sgn, sum, cmpa, cmpb, cmpd, wd, nzv;
   logic [16:0] sum17;
   logic        sum_c, ci;
   logic        wv, br, setnz, nzwide, modefix;
   logic [7:0]  p;

   always_comb begin
      mw = !p_ff[cpu16_pkg::FL_M];
      xw = !p_ff[cpu16_pkg::FL_X];
      am = mw ? 16'hFFFF : 16'h00FF;
      xm = xw ? 16'hFFFF : 16'h00FF;
      sgn = mw ? 16'h8000 : 16'h0080;
      ci = p_ff[cpu16_pkg::FL_C];
      cmpb = (kind == cpu16_pkg::OP_SBC) ? (~operand & am) : (operand & am);
      sum17 = {1'b0, acc_ff & am} + {1'b0, cmpb} + {16'd0, ci};
      sum = sum17[15:0] & am;
      sum_c = mw ? sum17[16] : sum17[8];
      cmpa = acc_ff;
      unique case (kind)
         cpu16_pkg::OP_CPX: cmpa = x_ff;
         cpu16_pkg::OP_CPY: cmpa = y_ff;
         default: cmpa = acc_ff;
      endcase
      cmpd = (cmpa - operand) & ((kind == cpu16_pkg::OP_CMP) ? am : xm);

      acc_in = acc_ff; x_in = x_ff; y_in = y_ff; sp_in = sp_ff; d_in = d_ff;
      e_in = e_ff; p = p_ff;
      wv = 1'b0; wd = '0; br = 1'b0; setnz = 1'b0; nzwide = mw; nzv = '0;
      modefix = 1'b0;
      unique case (kind)
         cpu16_pkg::OP_ADC, cpu16_pkg::OP_SBC: begin
            p[cpu16_pkg::FL_C] = sum_c;
            p[cpu16_pkg::FL_V] = |(~((acc_ff & am) ^ cmpb) & ((acc_ff & am) ^ sum) & sgn);
            acc_in = (acc_ff & ~am) | sum;
            setnz = 1'b1; nzv = acc_in;
         end
         cpu16_pkg::OP_AND, cpu16_pkg::OP_ORA, cpu16_pkg::OP_EOR, cpu16_pkg::OP_LDA,
         cpu16_pkg::OP_ASL, cpu16_pkg::OP_LSR, cpu16_pkg::OP_INA, cpu16_pkg::OP_DEA,
         cpu16_pkg::OP_TXA, cpu16_pkg::OP_TYA: begin
            unique case (kind)
               cpu16_pkg::OP_AND: nzv = acc_ff & operand;
               cpu16_pkg::OP_ORA: nzv = acc_ff | operand;
               cpu16_pkg::OP_EOR: nzv = acc_ff ^ operand;
               cpu16_pkg::OP_LDA: nzv = operand;
               cpu16_pkg::OP_ASL: begin
                  p[cpu16_pkg::FL_C] = |(acc_ff & sgn);
                  nzv = {acc_ff[14:0], 1'b0};
               end
               cpu16_pkg::OP_LSR: begin
                  p[cpu16_pkg::FL_C] = acc_ff[0];
                  nzv = (acc_ff & am) >> 1;
               end
               cpu16_pkg::OP_INA: nzv = acc_ff + 16'd1;
               cpu16_pkg::OP_DEA: nzv = acc_ff - 16'd1;
               cpu16_pkg::OP_TXA: nzv = x_ff;
               default:           nzv = y_ff;
            endcase
            acc_in = (acc_ff & ~am) | (nzv & am);
            setnz = 1'b1; nzv = acc_in;
         end
         cpu16_pkg::OP_CMP, cpu16_pkg::OP_CPX, cpu16_pkg::OP_CPY: begin
            p[cpu16_pkg::FL_C] = (cmpa & ((kind == cpu16_pkg::OP_CMP) ? am : xm))
                                 >= (operand & ((kind == cpu16_pkg::OP_CMP) ? am : xm));
            setnz = 1'b1; nzv = cmpd;
            nzwide = (kind == cpu16_pkg::OP_CMP) ? mw : xw;
         end
         cpu16_pkg::OP_BIT: begin
            p[cpu16_pkg::FL_Z] = ((operand & acc_ff & am) == 16'd0);
            p[cpu16_pkg::FL_N] = mw ? operand[15] : operand[7];
            p[cpu16_pkg::FL_V] = mw ? operand[14] : operand[6];
         end
         cpu16_pkg::OP_LDX, cpu16_pkg::OP_DEX, cpu16_pkg::OP_TAX, cpu16_pkg::OP_TSX: begin
            unique case (kind)
               cpu16_pkg::OP_LDX: x_in = operand & xm;
               cpu16_pkg::OP_DEX: x_in = (x_ff - 16'd1) & xm;
               cpu16_pkg::OP_TAX: x_in = acc_ff & xm;
               default:           x_in = sp_ff & xm;
            endcase
            setnz = 1'b1; nzv = x_in; nzwide = xw;
         end
         cpu16_pkg::OP_LDY, cpu16_pkg::OP_TAY: begin
            y_in = ((kind == cpu16_pkg::OP_LDY) ? operand : acc_ff) & xm;
            setnz = 1'b1; nzv = y_in; nzwide = xw;
         end
         cpu16_pkg::OP_STA: begin wv = 1'b1; wd = acc_ff & am; end
         cpu16_pkg::OP_STZ: begin wv = 1'b1; wd = '0; end
         cpu16_pkg::OP_INC, cpu16_pkg::OP_DEC: begin
            wv = 1'b1;
            wd = ((kind == cpu16_pkg::OP_INC) ? operand + 16'd1 : operand - 16'd1) & am;
            setnz = 1'b1; nzv = wd;
         end
         cpu16_pkg::OP_TXS:
            sp_in = e_ff ? {cpu16_pkg::STACK_PAGE, x_ff[7:0]} : x_ff;
         cpu16_pkg::OP_TCS:
            sp_in = e_ff ? {cpu16_pkg::STACK_PAGE, acc_ff[7:0]} : acc_ff;
         cpu16_pkg::OP_TCD: begin
            d_in = acc_ff; setnz = 1'b1; nzv = acc_ff; nzwide = 1'b1;
         end
         cpu16_pkg::OP_XBA: begin
            acc_in = {acc_ff[7:0], acc_ff[15:8]};
            setnz = 1'b1; nzv = acc_in; nzwide = 1'b0;
         end
         cpu16_pkg::OP_REP: begin p = p_ff & ~operand[7:0]; modefix = 1'b1; end
         cpu16_pkg::OP_SEP: begin p = p_ff | operand[7:0]; modefix = 1'b1; end
         cpu16_pkg::OP_PLP: begin p = operand[7:0]; modefix = 1'b1; end
         cpu16_pkg::OP_CLC: p[cpu16_pkg::FL_C] = 1'b0;
         cpu16_pkg::OP_SEI: p[cpu16_pkg::FL_I] = 1'b1;
         cpu16_pkg::OP_XCE: begin
            p[cpu16_pkg::FL_C] = e_ff;
            e_in = ci;
            if (ci) sp_in = {cpu16_pkg::STACK_PAGE, sp_ff[7:0]};
            modefix = 1'b1;
         end
         cpu16_pkg::OP_BRA: br = 1'b1;
         cpu16_pkg::OP_BEQ: br = p_ff[cpu16_pkg::FL_Z];
         cpu16_pkg::OP_BNE: br = !p_ff[cpu16_pkg::FL_Z];
         cpu16_pkg::OP_BCC: br = !p_ff[cpu16_pkg::FL_C];
         cpu16_pkg::OP_BCS: br = p_ff[cpu16_pkg::FL_C];
         cpu16_pkg::OP_BPL: br = !p_ff[cpu16_pkg::FL_N];
         cpu16_pkg::OP_BMI: br = p_ff[cpu16_pkg::FL_N];
         cpu16_pkg::OP_BVC: br = !p_ff[cpu16_pkg::FL_V];
         cpu16_pkg::OP_BVS: br = p_ff[cpu16_pkg::FL_V];
         default: ;
      endcase
      if (setnz) begin
         p[cpu16_pkg::FL_Z] = nzwide ? (nzv == 16'd0) : (nzv[7:0] == 8'd0);
         p[cpu16_pkg::FL_N] = nzwide ? nzv[15] : nzv[7];
      end
      if (modefix) begin
         if (e_in) begin
            p[cpu16_pkg::FL_X] = 1'b1;
            p[cpu16_pkg::FL_M] = 1'b1;
         end
         if (p[cpu16_pkg::FL_X]) begin
            x_in = {8'd0, x_ff[7:0]};
            y_in = {8'd0, y_ff[7:0]};
         end
      end
      p_in = p;
      result.status   = p_in;
      result.acc      = acc_in;
      result.wr_valid = wv;
      result.wr_data  = wd;
      result.wr_wide  = wv & mw;
      result.branch   = br;
   end

   a_emu_mx: assert property (@(posedge clock) disable iff (reset)
      e_ff |-> p_ff[cpu16_pkg::FL_M] && p_ff[cpu16_pkg::FL_X])
      else $error("emulation mode without M and X");
   a_narrow_x: assert property (@(posedge clock) disable iff (reset)
      $past(step && modefix) && p_ff[cpu16_pkg::FL_X] |-> x_ff[15:8] == 8'd0)
      else $error("index high byte kept while narrow");
   a_emu_sp: assert property (@(posedge clock) disable iff (reset)
      $past(step && kind == cpu16_pkg::OP_XCE && ci) |-> sp_ff[15:8] == cpu16_pkg::STACK_PAGE)
      else $error("stack page not forced on entering emulation");
endmodule

// ----- rtl/cpu_16bit_register_alu_execute_unit.sv -----
// Top level of the 65816-style execute unit: input acceptance and result register.
// Depends on cpu16_pkg and cpu16_core.
// One operation per cycle: each item is executed in one pass of logic at acceptance
// and its result appears in the result register in the next cycle; items are taken
// every cycle while the result register is empty or being drained.
module cpu_16bit_register_alu_execute_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [5:0]  req_kind,
   input  logic [15:0] req_operand,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_status_out,
   output logic [15:0] rsp_acc_out,
   output logic        rsp_write_valid,
   output logic [15:0] rsp_write_data,
   output logic        rsp_write_wide,
   output logic        rsp_branch_taken
);
   logic                  step, valid_ff;
   cpu16_pkg::result_type res, res_ff;

   assign req_stall = valid_ff && rsp_stall;
   assign step      = req_valid && !req_stall;

   cpu16_core u_core (
      .clock(clock), .reset(reset), .step(step),
      .kind(req_kind), .operand(req_operand), .result(res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         res_ff <= res;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status_out   = res_ff.status;
   assign rsp_acc_out      = res_ff.acc;
   assign rsp_write_valid  = res_ff.wr_valid;
   assign rsp_write_data   = res_ff.wr_data;
   assign rsp_write_wide   = res_ff.wr_wide;
   assign rsp_branch_taken = res_ff.branch;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(res_ff))
      else $error("result lost under stall");
   a_take: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid)
      else $error("accepted item gave no result");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("stall without pending result");
endmodule
